// ===== hdl/dns_name_label_encoder_assert.svh =====
// assertion macros used by the label encoder checker
`ifndef DNS_NAME_LABEL_ENCODER_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_ASSERT_SVH

// property that must hold on every clock edge outside reset
`define DNSLE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define DNSLE_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== hdl/dnsle_pkg.sv =====
// shared types and constants of the dns name label encoder
package dnsle_pkg;

   // width of the byte count and size of the label store
   localparam int CNT_W       = 6;
   localparam int STORE_DEPTH = 63;

   localparam logic [7:0] DOT_BYTE  = 8'h2E;
   localparam logic [7:0] ROOT_BYTE = 8'h00;

   // request command codes
   localparam logic CMD_BYTE   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // error codes carried on every result byte
   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_TRUNC   = 2'd1,
      ERR_DISCARD = 2'd2
   } err_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   // control word broadcast along the cell chain
   typedef struct packed {
      logic             push;
      logic             shift;
      logic [CNT_W-1:0] wr_idx;
      logic [7:0]       wr_byte;
   } chain_ctl_type;

endpackage

// ===== hdl/dns_name_label_encoder.sv =====
// top level of the dns name label encoder: sequencer plus chain of byte cells
//
// Requests carry one byte of a dotted host name (req_cmd = 0) or a finish
// command (req_cmd = 1). Results leave one wire byte per handshake on rsp_,
// with rsp_last marking the final byte caused by a request.
// A plain character is stored in the next free cell and gives no result.
// A dot gives the length byte in the cycle after the request is taken, then
// the held characters, one per cycle while the receiver takes them, shifted
// out of the head of the cell chain.
// A finish gives the zero root byte in the cycle after it is taken.
// All result bytes leave through one output register; req_ready is low
// while a label drains or while a result byte waits for the receiver.
// Characters beyond the clamped limit LIM are dropped and the label's bytes carry
// error code 1; a finish with a label still held discards it with code 2.
// A stalled receiver holds the output register; the chain and the
// sequencer wait with it. Synchronous reset empties the label and the
// output register; no clearing pass is run, cell contents are don't care.
module dns_name_label_encoder #(
   parameter int MAX_LABEL = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_name_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic [1:0] rsp_error_code
);

   // label limit clamped to between one and the store depth
   localparam int LIM = (MAX_LABEL > dnsle_pkg::STORE_DEPTH) ? dnsle_pkg::STORE_DEPTH :
                        (MAX_LABEL < 1) ? 1 : MAX_LABEL;

   dnsle_pkg::chain_ctl_type ctl;
   logic [7:0]               cell_q [LIM];

   dnsle_ctrl #(
      .LIMIT (LIM)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_name_byte  (req_name_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_error_code (rsp_error_code),
      .head_byte      (cell_q[0]),
      .ctl            (ctl)
   );

   // chain of cells, head at index zero
   for (genvar i = 0; i < LIM; i++) begin : g_cell
      logic [7:0] nbr;
      if (i == LIM - 1) begin : g_tail
         assign nbr = cell_q[i];
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      dnsle_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .next_byte (nbr),
         .cell_byte (cell_q[i])
      );
   end

endmodule

// ===== hdl/dnsle_cell.sv =====
// one label byte cell of the chain, loads a new byte, takes its right neighbor's or holds its own
module dnsle_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  dnsle_pkg::chain_ctl_type  ctl,
   input  logic [7:0]                next_byte,
   output logic [7:0]                cell_byte
);

   localparam logic [dnsle_pkg::CNT_W-1:0] MY_IDX = dnsle_pkg::CNT_W'(INDEX);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // write at this slot or shift toward the head
   always_comb begin
      byte_in = byte_ff;
      if (ctl.push && (ctl.wr_idx == MY_IDX)) begin
         byte_in = ctl.wr_byte;
      end else if (ctl.shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== hdl/dnsle_ctrl.sv =====
// sequencer: counts label bytes, emits length and root bytes, drains the chain
module dnsle_ctrl #(
   parameter int LIMIT = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [7:0]                req_name_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last,
   output logic [1:0]                rsp_error_code,
   input  logic [7:0]                head_byte,
   output dnsle_pkg::chain_ctl_type  ctl
);

   localparam logic [dnsle_pkg::CNT_W-1:0] LIM_C = dnsle_pkg::CNT_W'(LIMIT);
   localparam logic [dnsle_pkg::CNT_W-1:0] ONE_C = dnsle_pkg::CNT_W'(1);

   dnsle_pkg::state_type         state_ff, state_in;
   logic [dnsle_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [dnsle_pkg::CNT_W-1:0]  remain_ff, remain_in;
   logic                         ovf_ff, ovf_in;
   dnsle_pkg::err_type           err_ff, err_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   rsp_byte_ff, rsp_byte_in;
   logic                         rsp_last_ff, rsp_last_in;
   dnsle_pkg::err_type           rsp_err_ff, rsp_err_in;

   logic                         out_free;
   logic                         load;
   logic                         take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == dnsle_pkg::ST_IDLE) && out_free;
   assign take      = req_valid && req_ready;

   // next state, chain control and output register load
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      ovf_in      = ovf_ff;
      err_in      = err_ff;
      load        = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in  = rsp_err_ff;
      ctl.push    = 1'b0;
      ctl.shift   = 1'b0;
      ctl.wr_idx  = count_ff;
      ctl.wr_byte = req_name_byte;

      unique case (state_ff)
         dnsle_pkg::ST_IDLE: begin
            if (take) begin
               priority if (req_cmd == dnsle_pkg::CMD_FINISH) begin
                  // finish: root byte, drop any held label
                  load        = 1'b1;
                  rsp_byte_in = dnsle_pkg::ROOT_BYTE;
                  rsp_last_in = 1'b1;
                  rsp_err_in  = ((count_ff != '0) || ovf_ff) ?
                                dnsle_pkg::ERR_DISCARD : dnsle_pkg::ERR_OK;
                  count_in    = '0;
                  ovf_in      = 1'b0;
               end else if (req_name_byte != dnsle_pkg::DOT_BYTE) begin
                  // label character: store it or note truncation
                  if (count_ff < LIM_C) begin
                     ctl.push = 1'b1;
                     count_in = count_ff + ONE_C;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  // dot: length byte now, held bytes follow
                  load        = 1'b1;
                  rsp_byte_in = 8'(count_ff);
                  rsp_last_in = (count_ff == '0);
                  rsp_err_in  = ovf_ff ? dnsle_pkg::ERR_TRUNC : dnsle_pkg::ERR_OK;
                  err_in      = ovf_ff ? dnsle_pkg::ERR_TRUNC : dnsle_pkg::ERR_OK;
                  remain_in   = count_ff;
                  count_in    = '0;
                  ovf_in      = 1'b0;
                  if (count_ff != '0) begin
                     state_in = dnsle_pkg::ST_DRAIN;
                  end
               end
            end
         end
         dnsle_pkg::ST_DRAIN: begin
            // one held byte per cycle from the head cell while the output is free
            if (out_free) begin
               load        = 1'b1;
               rsp_byte_in = head_byte;
               rsp_last_in = (remain_ff == ONE_C);
               rsp_err_in  = err_ff;
               ctl.shift   = 1'b1;
               remain_in   = remain_ff - ONE_C;
               if (remain_ff == ONE_C) begin
                  state_in = dnsle_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = dnsle_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnsle_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error_code = rsp_err_ff;

endmodule

// ===== hdl/dnsle_checker.sv =====
// port-level checker for the dns name label encoder, bound to the top level
`include "dns_name_label_encoder_assert.svh"

module dnsle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_cmd,
   input logic [7:0] req_name_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic [1:0] rsp_error_code
);

   // a stalled result byte stays put
   `DNSLE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte), "result byte changed while stalled")

   // finish gives the root byte in the next cycle
   `DNSLE_ASSERT(a_root, req_valid && req_ready && req_cmd |=> rsp_valid && rsp_out_byte == dnsle_pkg::ROOT_BYTE && rsp_last, "finish did not give root byte")

   // a label character gives no result
   `DNSLE_ASSERT(a_char_quiet, req_valid && req_ready && !req_cmd && req_name_byte != dnsle_pkg::DOT_BYTE |=> !rsp_valid, "label character gave a result")

   // discard code only on the final root byte
   `DNSLE_NEVER(a_discard, rsp_valid && rsp_error_code == dnsle_pkg::ERR_DISCARD && (!rsp_last || rsp_out_byte != dnsle_pkg::ROOT_BYTE), "discard code on a non-root byte")

endmodule

bind dns_name_label_encoder dnsle_checker u_dnsle_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_cmd        (req_cmd),
   .req_name_byte  (req_name_byte),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_last       (rsp_last),
   .rsp_error_code (rsp_error_code)
);
